@@ rtl/core/key_state_autorepeat_tracker_assert.svh @@
// assertion macros shared by the key state autorepeat tracker rtl
`ifndef KEY_STATE_AUTOREPEAT_TRACKER_ASSERT_SVH
`define KEY_STATE_AUTOREPEAT_TRACKER_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define KSAT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define KSAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ksat_pkg.sv @@
// shared types and constants of the key state autorepeat tracker
package ksat_pkg;

   // fixed field widths
   localparam int KEY_WIDTH         = 32;
   localparam int TIME_WIDTH        = 32;
   localparam int MS_WIDTH          = 16;
   localparam int KEY_INDEX_WIDTH   = 5;
   localparam int DIR_WIDTH         = 3;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int REQ_DATA_WIDTH    = 64;
   localparam int RSP_DATA_WIDTH    = 104;

   // default key count
   localparam int NUM_KEYS_DEFAULT  = 32;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_DELAY    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_INDEX      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_INDEX      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_INDEX     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_INDEX        = 3'd5;

   // register reset values
   localparam logic [MS_WIDTH-1:0]        REPEAT_DELAY_RESET    = 16'd400;
   localparam logic [MS_WIDTH-1:0]        REPEAT_INTERVAL_RESET = 16'd100;
   localparam logic [KEY_INDEX_WIDTH-1:0] DOWN_INDEX_RESET      = 5'd0;
   localparam logic [KEY_INDEX_WIDTH-1:0] LEFT_INDEX_RESET      = 5'd1;
   localparam logic [KEY_INDEX_WIDTH-1:0] RIGHT_INDEX_RESET     = 5'd2;
   localparam logic [KEY_INDEX_WIDTH-1:0] UP_INDEX_RESET        = 5'd3;

   // four-way direction codes
   typedef enum logic [DIR_WIDTH-1:0] {
      DIR_NONE  = 3'd0,
      DIR_UP    = 3'd1,
      DIR_DOWN  = 3'd2,
      DIR_LEFT  = 3'd3,
      DIR_RIGHT = 3'd4
   } dir_type;

   // frame-wide values every key lane sees
   typedef struct packed {
      logic                  accept;
      logic [TIME_WIDTH-1:0] now;
      logic [MS_WIDTH-1:0]   delay;
      logic [MS_WIDTH:0]     threshold;
      logic [TIME_WIDTH-1:0] rebase;
   } lane_ctl_type;

   // direction key positions
   typedef struct packed {
      logic [KEY_INDEX_WIDTH-1:0] up;
      logic [KEY_INDEX_WIDTH-1:0] down;
      logic [KEY_INDEX_WIDTH-1:0] left;
      logic [KEY_INDEX_WIDTH-1:0] right;
   } dir_idx_type;

   // one finished result
   typedef struct packed {
      dir_type              direction;
      logic [KEY_WIDTH-1:0] repeated;
      logic [KEY_WIDTH-1:0] triggered;
      logic [KEY_WIDTH-1:0] pressed;
   } rsp_item_type;

endpackage

@@ rtl/core/ksat_lane.sv @@
// one key lane: repeat stamp and press or repeat decision
module ksat_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  ksat_pkg::lane_ctl_type key_ctl,
   input  logic                  held_bit,
   input  logic                  prev_bit,
   output logic                  fire
);
   import ksat_pkg::*;

   logic [TIME_WIDTH-1:0] stamp_ff;
   logic [TIME_WIDTH-1:0] stamp_in;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  past_delay;
   logic                  past_interval;

   // hold time since the stamp, modulo 2^32
   assign elapsed       = key_ctl.now - stamp_ff;
   assign past_delay    = elapsed > {{(TIME_WIDTH-MS_WIDTH){1'b0}}, key_ctl.delay};
   // elapsed - delay >= interval, without the second subtract
   assign past_interval = {1'b0, elapsed} >=
                          {{(TIME_WIDTH-MS_WIDTH){1'b0}}, key_ctl.threshold};

   // fire on first held frame, then on each repeat
   assign fire = held_bit & (~prev_bit | (past_delay & past_interval));

   // new stamp: now on press, now minus delay on repeat
   always_comb begin
      stamp_in = stamp_ff;
      if (key_ctl.accept && fire) begin
         stamp_in = prev_bit ? key_ctl.rebase : key_ctl.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else begin
         stamp_ff <= stamp_in;
      end
   end

endmodule

@@ rtl/core/ksat_dir.sv @@
// four-way direction latch with opposite-direction lockout
module ksat_dir (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ksat_pkg::KEY_WIDTH-1:0] held,
   input  ksat_pkg::dir_idx_type         dir_idx,
   output ksat_pkg::dir_type             dir_next
);
   import ksat_pkg::*;

   dir_type dir_ff;
   dir_type dir_in;

   // up or down first, then left or right
   always_comb begin
      if (held[dir_idx.up] && dir_ff != DIR_DOWN) begin
         dir_next = DIR_UP;
      end else if (held[dir_idx.down] && dir_ff != DIR_UP) begin
         dir_next = DIR_DOWN;
      end else if (held[dir_idx.left] && dir_ff != DIR_RIGHT) begin
         dir_next = DIR_LEFT;
      end else if (held[dir_idx.right] && dir_ff != DIR_LEFT) begin
         dir_next = DIR_RIGHT;
      end else begin
         dir_next = DIR_NONE;
      end
   end

   // latch on each accepted frame
   assign dir_in = accept ? dir_next : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= DIR_NONE;
      end else begin
         dir_ff <= dir_in;
      end
   end

endmodule

@@ rtl/core/ksat_merge.sv @@
// two-entry result queue that gathers lane and direction results
module ksat_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ksat_pkg::rsp_item_type push_item,
   input  logic                   pop,
   output logic                   has_room,
   output logic                   item_valid,
   output ksat_pkg::rsp_item_type item
);
   import ksat_pkg::*;

   rsp_item_type entry_ff [2];
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic         do_push;
   logic         do_pop;

   assign has_room   = count_ff != 2'd2;
   assign item_valid = count_ff != 2'd0;
   assign item       = entry_ff[rd_ptr_ff];
   assign do_push    = push && has_room;
   assign do_pop     = pop && item_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // result storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/key_state_autorepeat_tracker.sv @@
// top level of the key state autorepeat tracker
// Takes one frame request per clock while the output queue has room: a held-key
// bitmap and a millisecond timestamp. Every tracked key has its own lane with a
// repeat stamp, so all keys are evaluated in parallel; the frame's result
// (pressed, newly triggered, fired keys and the latched direction) is written
// into a two-entry output queue, so requests keep flowing while one result is
// stalled. req_tready drops only when both queue entries are full. The user
// must write registers only while the block is idle; the block itself does
// not enforce this. A write takes effect on the next request. No clearing
// pass is run after reset; the block is ready in the first cycle.
`include "key_state_autorepeat_tracker_assert.svh"

module key_state_autorepeat_tracker #(
   parameter int NUM_KEYS = ksat_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] held_now, [63:32] time_ms
   input  logic [ksat_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] pressed_keys, [63:32] triggered_keys, [95:64] repeated_keys,
   // [98:96] direction, [103:99] zero
   output logic [ksat_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ksat_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ksat_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ksat_pkg::*;

   // keys above bit 31 never reach a lane
   localparam int LANES = (NUM_KEYS > KEY_WIDTH) ? KEY_WIDTH : NUM_KEYS;
   localparam logic [KEY_WIDTH-1:0] KeyMask =
      (LANES >= KEY_WIDTH) ? {KEY_WIDTH{1'b1}} :
      KEY_WIDTH'((64'd1 << LANES) - 64'd1);

   logic [MS_WIDTH-1:0]        delay_ff,    delay_in;
   logic [MS_WIDTH-1:0]        interval_ff, interval_in;
   logic [KEY_INDEX_WIDTH-1:0] down_ff,     down_in;
   logic [KEY_INDEX_WIDTH-1:0] left_ff,     left_in;
   logic [KEY_INDEX_WIDTH-1:0] right_ff,    right_in;
   logic [KEY_INDEX_WIDTH-1:0] up_ff,       up_in;
   logic [KEY_WIDTH-1:0]       held_ff,     held_in;

   logic                       accept;
   logic [KEY_WIDTH-1:0]       held;
   logic [TIME_WIDTH-1:0]      now;
   logic [KEY_WIDTH-1:0]       fire;
   lane_ctl_type               key_ctl;
   dir_idx_type                dir_idx;
   dir_type                    dir_next;
   rsp_item_type               push_item;
   rsp_item_type               rsp_item;

   // register writes, always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      delay_in    = delay_ff;
      interval_in = interval_ff;
      down_in     = down_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      up_in       = up_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REPEAT_DELAY:    delay_in    = csr_data;
            CSR_REPEAT_INTERVAL: interval_in = csr_data;
            CSR_DOWN_INDEX:      down_in     = csr_data[KEY_INDEX_WIDTH-1:0];
            CSR_LEFT_INDEX:      left_in     = csr_data[KEY_INDEX_WIDTH-1:0];
            CSR_RIGHT_INDEX:     right_in    = csr_data[KEY_INDEX_WIDTH-1:0];
            CSR_UP_INDEX:        up_in       = csr_data[KEY_INDEX_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= REPEAT_DELAY_RESET;
         interval_ff <= REPEAT_INTERVAL_RESET;
         down_ff     <= DOWN_INDEX_RESET;
         left_ff     <= LEFT_INDEX_RESET;
         right_ff    <= RIGHT_INDEX_RESET;
         up_ff       <= UP_INDEX_RESET;
      end else begin
         delay_ff    <= delay_in;
         interval_ff <= interval_in;
         down_ff     <= down_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         up_ff       <= up_in;
      end
   end

   // request fields
   assign accept = req_tvalid && req_tready;
   assign held   = req_tdata[KEY_WIDTH-1:0] & KeyMask;
   assign now    = req_tdata[KEY_WIDTH +: TIME_WIDTH];

   // previous frame's held bitmap
   assign held_in = accept ? held : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // frame-wide values shared by all lanes
   assign key_ctl.accept    = accept;
   assign key_ctl.now       = now;
   assign key_ctl.delay     = delay_ff;
   assign key_ctl.threshold = {1'b0, delay_ff} + {1'b0, interval_ff};
   assign key_ctl.rebase    = now - {{(TIME_WIDTH-MS_WIDTH){1'b0}}, delay_ff};

   // one lane per tracked key
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      ksat_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .key_ctl  (key_ctl),
         .held_bit (held[i]),
         .prev_bit (held_ff[i]),
         .fire     (fire[i])
      );
   end

   for (genvar i = LANES; i < KEY_WIDTH; i++) begin : g_idle
      assign fire[i] = 1'b0;
   end

   // direction latch
   assign dir_idx.up    = up_ff;
   assign dir_idx.down  = down_ff;
   assign dir_idx.left  = left_ff;
   assign dir_idx.right = right_ff;

   ksat_dir u_dir (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .held     (held),
      .dir_idx  (dir_idx),
      .dir_next (dir_next)
   );

   // gather lane results into one item
   assign push_item.pressed   = held;
   assign push_item.triggered = held & ~held_ff;
   assign push_item.repeated  = fire;
   assign push_item.direction = dir_next;

   ksat_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (push_item),
      .pop        (rsp_tready),
      .has_room   (req_tready),
      .item_valid (rsp_tvalid),
      .item       (rsp_item)
   );

   assign rsp_tdata = {
      {(RSP_DATA_WIDTH - 3*KEY_WIDTH - DIR_WIDTH){1'b0}},
      rsp_item.direction,
      rsp_item.repeated,
      rsp_item.triggered,
      rsp_item.pressed
   };

   // a fired key is always a held key
   `KSAT_ASSERT_NOW(a_fire_held, rsp_tvalid, (rsp_tdata[95:64] & ~rsp_tdata[31:0]) == 32'd0, "fired key not held")
   // every new press fires
   `KSAT_ASSERT_NOW(a_trig_fires, rsp_tvalid, (rsp_tdata[63:32] & ~rsp_tdata[95:64]) == 32'd0, "new press did not fire")
   // direction code stays in range
   `KSAT_ASSERT_NOW(a_dir_range, rsp_tvalid, rsp_tdata[98:96] <= 3'd4, "direction code out of range")
   // an accepted request leaves a result behind
   `KSAT_ASSERT_NEXT(a_req_to_rsp, req_tvalid && req_tready, rsp_tvalid, "accepted request lost")

endmodule
